// ===== rtl/core/lbt_pkg.sv =====
// Shared types and constants for the LED breathing triangle generator.
// Used by every module of the block; depends on nothing.
package lbt_pkg;

   // Field widths
   localparam int unsigned BRIGHT_W   = 8;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned DELAY_W    = 32;
   localparam int unsigned HALF_W     = 15;
   localparam int unsigned PHASE_W    = 16;
   localparam int unsigned PROD_W     = BRIGHT_W + HALF_W;
   localparam int unsigned DIVIDEND_W = DELAY_W;
   localparam int unsigned DIVISOR_W  = PHASE_W;
   localparam int unsigned STEP_W     = $clog2(DIVIDEND_W);

   localparam logic [BRIGHT_W-1:0] MAX_BRIGHT_RESET = 8'd255;

   // Input command codes
   typedef enum logic [1:0] {
      CMD_TICK         = 2'd0,
      CMD_START_CONT   = 2'd1,
      CMD_BREATHE_ONCE = 2'd2,
      CMD_STOP         = 2'd3
   } cmd_type;

   // Run mode as reported on the result channel
   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_CONT = 2'd1,
      MODE_ONCE = 2'd2
   } mode_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_MULT,
      S_DIV_GO,
      S_DIV_RUN,
      S_APPLY,
      S_OUTPUT
   } ctrl_state_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MULT,
      OP_DIV_GO,
      OP_IDLE_TICK,
      OP_END_ONCE,
      OP_ZERO_TICK,
      OP_ZERO_START,
      OP_STOP,
      OP_APPLY
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      mode_type mode;
      logic     h_zero;
      logic     h_new_zero;
      logic     once_wrap;
      logic     div_done;
      logic     slot_free;
   } dp_status_type;

endpackage

// ===== rtl/core/lbt_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Uses lbt_pkg for widths. Divisor must be nonzero.
module lbt_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lbt_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [lbt_pkg::DIVISOR_W-1:0]    divisor,
   output logic [lbt_pkg::DIVIDEND_W-1:0]   quotient,
   output logic [lbt_pkg::DIVISOR_W-1:0]    remainder,
   output logic                             done
);

   logic [lbt_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [lbt_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [lbt_pkg::DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [lbt_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [lbt_pkg::DIVISOR_W:0]    rem_shift;
   logic [lbt_pkg::DIVISOR_W:0]    rem_diff;
   logic                           fits;

   // One trial subtract per step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[lbt_pkg::DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      fits      = (rem_shift >= {1'b0, dsr_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[lbt_pkg::DIVIDEND_W-2:0], fits};
         rem_in  = fits ? rem_diff[lbt_pkg::DIVISOR_W-1:0]
                        : rem_shift[lbt_pkg::DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == lbt_pkg::STEP_W'(lbt_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== rtl/core/lbt_dp.sv =====
// Datapath: breath state, multiplier, shared divider and the result register.
// Uses lbt_pkg and instantiates lbt_div; driven by lbt_ctrl operations.
module lbt_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lbt_pkg::BRIGHT_W-1:0]    csr_wr_data,
   input  logic [1:0]                      req_command,
   input  logic [lbt_pkg::DUR_W-1:0]       req_cycle_duration,
   input  logic [lbt_pkg::DELAY_W-1:0]     req_start_delay,
   input  lbt_pkg::ctrl_cmd_type           ctrl,
   output lbt_pkg::dp_status_type          status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [lbt_pkg::BRIGHT_W-1:0]    rsp_brightness,
   output logic [1:0]                      rsp_mode,
   output logic                            rsp_cycle_done
);

   // Configuration and captured request
   logic [lbt_pkg::BRIGHT_W-1:0] max_ff;
   lbt_pkg::cmd_type             cmd_ff, cmd_in;
   logic [lbt_pkg::HALF_W-1:0]   hnew_ff, hnew_in;
   logic [lbt_pkg::DELAY_W-1:0]  dly_ff, dly_in;

   // Breath state
   lbt_pkg::mode_type            mode_ff, mode_in;
   logic [lbt_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lbt_pkg::HALF_W-1:0]   h_ff, h_in;
   logic [lbt_pkg::PHASE_W-1:0]  prev_ff, prev_in;

   // Working values
   logic [lbt_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [lbt_pkg::BRIGHT_W-1:0] bright_ff, bright_in;
   logic                         done_ff, done_in;

   // Result register
   logic                         rsp_valid_ff;
   logic [lbt_pkg::BRIGHT_W-1:0] rsp_bright_ff;
   lbt_pkg::mode_type            rsp_mode_ff;
   logic                         rsp_done_ff;

   // Divider hookup
   logic                           div_start;
   logic [lbt_pkg::DIVIDEND_W-1:0] div_dividend;
   logic [lbt_pkg::DIVISOR_W-1:0]  div_divisor;
   logic [lbt_pkg::DIVIDEND_W-1:0] div_quot;
   logic [lbt_pkg::DIVISOR_W-1:0]  div_rem;
   logic                           div_done;

   // Derived values
   logic [lbt_pkg::PHASE_W-1:0]  per;
   logic [lbt_pkg::PHASE_W-1:0]  per_new;
   logic [lbt_pkg::PHASE_W-1:0]  fall_num;
   logic [lbt_pkg::HALF_W-1:0]   num;
   logic [lbt_pkg::PHASE_W-1:0]  phase_inc;
   logic [lbt_pkg::PHASE_W-1:0]  phase_adv;
   logic [lbt_pkg::PHASE_W:0]    once_sum;
   logic [lbt_pkg::PHASE_W:0]    once_wrapd;
   logic [lbt_pkg::PHASE_W-1:0]  once_phase;

   lbt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   // Triangle numerator, phase advance and once-mode start phase
   always_comb begin
      per       = {h_ff, 1'b0};
      per_new   = {hnew_ff, 1'b0};
      fall_num  = per - phase_ff;
      num       = (phase_ff < {1'b0, h_ff}) ? phase_ff[lbt_pkg::HALF_W-1:0]
                                            : fall_num[lbt_pkg::HALF_W-1:0];
      phase_inc = phase_ff + 1'b1;
      phase_adv = (phase_inc >= per) ? '0 : phase_inc;
      once_sum  = {2'b00, hnew_ff} + {1'b0, per_new} - {1'b0, div_rem};
      once_wrapd = once_sum - {1'b0, per_new};
      once_phase = (once_sum >= {1'b0, per_new}) ? once_wrapd[lbt_pkg::PHASE_W-1:0]
                                                 : once_sum[lbt_pkg::PHASE_W-1:0];
   end

   // Divider operand select
   always_comb begin
      div_start = (ctrl.op == lbt_pkg::OP_DIV_GO);
      if (cmd_ff == lbt_pkg::CMD_TICK) begin
         div_dividend = lbt_pkg::DIVIDEND_W'(prod_ff);
         div_divisor  = {1'b0, h_ff};
      end else begin
         div_dividend = dly_ff;
         div_divisor  = per_new;
      end
   end

   // Operation decode
   always_comb begin
      cmd_in    = cmd_ff;
      hnew_in   = hnew_ff;
      dly_in    = dly_ff;
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      h_in      = h_ff;
      prev_in   = prev_ff;
      prod_in   = prod_ff;
      bright_in = bright_ff;
      done_in   = done_ff;
      unique case (ctrl.op)
         lbt_pkg::OP_CAPTURE: begin
            cmd_in    = lbt_pkg::cmd_type'(req_command);
            hnew_in   = req_cycle_duration[lbt_pkg::DUR_W-1:1];
            dly_in    = req_start_delay;
            bright_in = '0;
            done_in   = 1'b0;
         end
         lbt_pkg::OP_MULT: begin
            prod_in = lbt_pkg::PROD_W'(max_ff) * lbt_pkg::PROD_W'(num);
         end
         lbt_pkg::OP_END_ONCE: begin
            mode_in = lbt_pkg::MODE_OFF;
            done_in = 1'b1;
         end
         lbt_pkg::OP_ZERO_TICK: begin
            prev_in  = phase_ff;
            phase_in = '0;
         end
         lbt_pkg::OP_ZERO_START: begin
            h_in     = hnew_ff;
            phase_in = '0;
            prev_in  = '0;
            mode_in  = (cmd_ff == lbt_pkg::CMD_START_CONT) ? lbt_pkg::MODE_CONT
                                                          : lbt_pkg::MODE_ONCE;
         end
         lbt_pkg::OP_STOP: begin
            mode_in = lbt_pkg::MODE_OFF;
         end
         lbt_pkg::OP_APPLY: begin
            if (cmd_ff == lbt_pkg::CMD_TICK) begin
               bright_in = div_quot[lbt_pkg::BRIGHT_W-1:0];
               prev_in   = phase_ff;
               phase_in  = phase_adv;
            end else begin
               h_in    = hnew_ff;
               prev_in = '0;
               if (cmd_ff == lbt_pkg::CMD_START_CONT) begin
                  phase_in = div_rem;
                  mode_in  = lbt_pkg::MODE_CONT;
               end else begin
                  phase_in = once_phase;
                  mode_in  = lbt_pkg::MODE_ONCE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= lbt_pkg::MAX_BRIGHT_RESET;
         mode_ff  <= lbt_pkg::MODE_OFF;
         phase_ff <= '0;
         h_ff     <= '0;
         prev_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         h_ff     <= h_in;
         prev_ff  <= prev_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      hnew_ff   <= hnew_in;
      dly_ff    <= dly_in;
      prod_ff   <= prod_in;
      bright_ff <= bright_in;
      done_ff   <= done_in;
   end

   // Result register: loaded when the slot is free, cleared on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_bright_ff <= bright_ff;
         rsp_mode_ff   <= mode_ff;
         rsp_done_ff   <= done_ff;
      end
   end

   // Status to the controller
   always_comb begin
      status.cmd        = cmd_ff;
      status.mode       = mode_ff;
      status.h_zero     = (h_ff == '0);
      status.h_new_zero = (hnew_ff == '0);
      status.once_wrap  = (prev_ff > phase_ff);
      status.div_done   = div_done;
      status.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_brightness = rsp_bright_ff;
   assign rsp_mode       = rsp_mode_ff;
   assign rsp_cycle_done = rsp_done_ff;

`ifndef ASSERT_OFF
   a_phase_in_period: assert property (@(posedge clock) disable iff (reset)
      (h_ff != '0) |-> (phase_ff < {h_ff, 1'b0}))
      else $error("phase outside its period");
   a_phase_zero_half: assert property (@(posedge clock) disable iff (reset)
      (h_ff == '0) |-> (phase_ff == '0))
      else $error("phase nonzero with zero half period");
   a_done_dark: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == lbt_pkg::OP_END_ONCE) |=> (done_ff && bright_ff == '0
         && mode_ff == lbt_pkg::MODE_OFF))
      else $error("completed breath not dark and off");
`endif

endmodule

// ===== rtl/core/lbt_ctrl.sv =====
// Controller state machine: sequences capture, multiply, divide and result load.
// Uses lbt_pkg; steers lbt_dp through command and status structs.
module lbt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lbt_pkg::dp_status_type  status,
   output lbt_pkg::ctrl_cmd_type   cmd
);

   lbt_pkg::ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbt_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = lbt_pkg::S_DISPATCH;
            end
         end
         lbt_pkg::S_DISPATCH: begin
            unique case (status.cmd)
               lbt_pkg::CMD_TICK: begin
                  if (status.mode == lbt_pkg::MODE_OFF) begin
                     state_in = lbt_pkg::S_OUTPUT;
                  end else if (status.mode == lbt_pkg::MODE_ONCE && status.once_wrap) begin
                     state_in = lbt_pkg::S_OUTPUT;
                  end else if (status.h_zero) begin
                     state_in = lbt_pkg::S_OUTPUT;
                  end else begin
                     state_in = lbt_pkg::S_MULT;
                  end
               end
               lbt_pkg::CMD_START_CONT, lbt_pkg::CMD_BREATHE_ONCE: begin
                  state_in = status.h_new_zero ? lbt_pkg::S_OUTPUT : lbt_pkg::S_DIV_GO;
               end
               default: state_in = lbt_pkg::S_OUTPUT;
            endcase
         end
         lbt_pkg::S_MULT:    state_in = lbt_pkg::S_DIV_GO;
         lbt_pkg::S_DIV_GO:  state_in = lbt_pkg::S_DIV_RUN;
         lbt_pkg::S_DIV_RUN: begin
            if (status.div_done) begin
               state_in = lbt_pkg::S_APPLY;
            end
         end
         lbt_pkg::S_APPLY:   state_in = lbt_pkg::S_OUTPUT;
         lbt_pkg::S_OUTPUT: begin
            if (status.slot_free) begin
               state_in = lbt_pkg::S_IDLE;
            end
         end
         default: state_in = lbt_pkg::S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = lbt_pkg::OP_NONE;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         lbt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = lbt_pkg::OP_CAPTURE;
            end
         end
         lbt_pkg::S_DISPATCH: begin
            unique case (status.cmd)
               lbt_pkg::CMD_TICK: begin
                  if (status.mode == lbt_pkg::MODE_OFF) begin
                     cmd.op = lbt_pkg::OP_IDLE_TICK;
                  end else if (status.mode == lbt_pkg::MODE_ONCE && status.once_wrap) begin
                     cmd.op = lbt_pkg::OP_END_ONCE;
                  end else if (status.h_zero) begin
                     cmd.op = lbt_pkg::OP_ZERO_TICK;
                  end
               end
               lbt_pkg::CMD_START_CONT, lbt_pkg::CMD_BREATHE_ONCE: begin
                  if (status.h_new_zero) begin
                     cmd.op = lbt_pkg::OP_ZERO_START;
                  end
               end
               default: cmd.op = lbt_pkg::OP_STOP;
            endcase
         end
         lbt_pkg::S_MULT:    cmd.op = lbt_pkg::OP_MULT;
         lbt_pkg::S_DIV_GO:  cmd.op = lbt_pkg::OP_DIV_GO;
         lbt_pkg::S_DIV_RUN: cmd.op = lbt_pkg::OP_NONE;
         lbt_pkg::S_APPLY:   cmd.op = lbt_pkg::OP_APPLY;
         lbt_pkg::S_OUTPUT:  cmd.out_load = status.slot_free;
         default: cmd.op = lbt_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_div_done_in_run: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == lbt_pkg::S_DIV_RUN))
      else $error("divider finished outside its wait state");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == lbt_pkg::S_DISPATCH))
      else $error("accepted request not dispatched");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (status.slot_free && state_ff == lbt_pkg::S_OUTPUT))
      else $error("result loaded over a pending result");
`endif

endmodule

// ===== rtl/core/led_breathing_triangle_generator.sv =====
// Top level of the LED breathing triangle generator.
// Uses lbt_pkg; joins lbt_ctrl (sequencer) and lbt_dp (datapath with divider).
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    command, cycle_duration, start_delay
//   rsp_      out        rsp_valid/rsp_ready    brightness, mode, cycle_done
//   csr_      in         csr_wr_en              wr_data = max_brightness
//
// One item at a time. A tick that advances a running breath steps through dispatch,
// multiply, the 32-step restoring divider and apply; a start with a nonzero half period
// skips multiply. The divider dominates. Other items go from dispatch to output.
// The block is ready again in the cycle after the result is loaded, so a new request
// is taken while the previous result still waits in the output register; a stalled
// result holds the block in its output state.
// Reset is synchronous: block off, phase and half period zero, peak level 255.
module led_breathing_triangle_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lbt_pkg::BRIGHT_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [lbt_pkg::DUR_W-1:0]     req_cycle_duration,
   input  logic [lbt_pkg::DELAY_W-1:0]   req_start_delay,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lbt_pkg::BRIGHT_W-1:0]  rsp_brightness,
   output logic [1:0]                    rsp_mode,
   output logic                          rsp_cycle_done
);

   lbt_pkg::ctrl_cmd_type  ctrl_cmd;
   lbt_pkg::dp_status_type dp_status;

   lbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   lbt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_command        (req_command),
      .req_cycle_duration (req_cycle_duration),
      .req_start_delay    (req_start_delay),
      .ctrl               (ctrl_cmd),
      .status             (dp_status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_brightness     (rsp_brightness),
      .rsp_mode           (rsp_mode),
      .rsp_cycle_done     (rsp_cycle_done)
   );

endmodule

// ===== tb/breath_level_checker.sv =====
// Checker for the LED breathing triangle generator: watches the request, response and
// register ports, predicts each response and compares it. Depends on lbt_pkg.
module breath_level_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lbt_pkg::BRIGHT_W-1:0]   csr_wr_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_command,
   input  logic [lbt_pkg::DUR_W-1:0]      req_cycle_duration,
   input  logic [lbt_pkg::DELAY_W-1:0]    req_start_delay,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [lbt_pkg::BRIGHT_W-1:0]   rsp_brightness,
   input  logic [1:0]                     rsp_mode,
   input  logic                           rsp_cycle_done,
   output int                             fault_count,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [lbt_pkg::BRIGHT_W-1:0] brightness;
      lbt_pkg::mode_type            mode;
      logic                         cycle_done;
   } breath_result_type;

   // Predicted generator state
   lbt_pkg::mode_type             lit_mode;
   logic [lbt_pkg::PHASE_W-1:0]   phase_at;
   logic [lbt_pkg::HALF_W-1:0]    half_span;
   logic [lbt_pkg::PHASE_W-1:0]   last_phase;
   logic [lbt_pkg::BRIGHT_W-1:0]  peak_level;

   breath_result_type pending_levels[$];

   // Triangle level for a phase; zero half period gives zero without dividing
   function automatic logic [lbt_pkg::BRIGHT_W-1:0] triangle_level(
         input logic [lbt_pkg::PHASE_W-1:0] ph,
         input logic [lbt_pkg::HALF_W-1:0] h);
      int unsigned num;
      if (h == '0) return '0;
      num = (ph < h) ? 32'(ph) : 2 * 32'(h) - 32'(ph);
      return lbt_pkg::BRIGHT_W'((32'(peak_level) * num) / 32'(h));
   endfunction

   // Advance the predicted state by one command and build its response
   task automatic predict_breath(input lbt_pkg::cmd_type c,
                                 input logic [lbt_pkg::DUR_W-1:0] dur,
                                 input logic [lbt_pkg::DELAY_W-1:0] dly,
                                 output breath_result_type res);
      int unsigned span;
      int unsigned rem;
      int unsigned nxt;
      logic [lbt_pkg::HALF_W-1:0] h;
      res = '0;
      case (c)
         lbt_pkg::CMD_TICK: begin
            if (lit_mode != lbt_pkg::MODE_OFF) begin
               span = 2 * 32'(half_span);
               if (lit_mode == lbt_pkg::MODE_ONCE && last_phase > phase_at) begin
                  // phase wrapped: the single breath is over
                  lit_mode = lbt_pkg::MODE_OFF;
                  res.cycle_done = 1'b1;
               end else begin
                  res.brightness = triangle_level(phase_at, half_span);
                  last_phase = phase_at;
                  nxt = 32'(phase_at) + 1;
                  if (span == 0 || nxt >= span) phase_at = '0;
                  else phase_at = lbt_pkg::PHASE_W'(nxt);
               end
            end
         end
         lbt_pkg::CMD_START_CONT, lbt_pkg::CMD_BREATHE_ONCE: begin
            h = dur[lbt_pkg::DUR_W-1:1];
            span = 2 * 32'(h);
            half_span = h;
            last_phase = '0;
            if (span == 0) begin
               phase_at = '0;
            end else begin
               rem = dly % span;
               if (c == lbt_pkg::CMD_START_CONT) phase_at = lbt_pkg::PHASE_W'(rem);
               else phase_at = lbt_pkg::PHASE_W'((32'(h) + span - rem) % span);
            end
            lit_mode = (c == lbt_pkg::CMD_START_CONT) ? lbt_pkg::MODE_CONT
                                                      : lbt_pkg::MODE_ONCE;
         end
         default: lit_mode = lbt_pkg::MODE_OFF;
      endcase
      res.mode = lit_mode;
   endtask

   // Sample all ports at the rising edge
   always @(posedge clock) begin
      breath_result_type want;
      breath_result_type got;
      if (reset) begin
         lit_mode = lbt_pkg::MODE_OFF;
         phase_at = '0;
         half_span = '0;
         last_phase = '0;
         peak_level = lbt_pkg::MAX_BRIGHT_RESET;
         pending_levels.delete();
         fault_count = 0;
      end else begin
         if (csr_wr_en) peak_level = csr_wr_data;

         // response transfer: compare against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.brightness = rsp_brightness;
            got.mode = lbt_pkg::mode_type'(rsp_mode);
            got.cycle_done = rsp_cycle_done;
            if (pending_levels.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected response: expected none,%s", $time,
                        $sformatf(" got bright=%0d mode=%0d done=%0d",
                                  got.brightness, rsp_mode, got.cycle_done));
            end else begin
               want = pending_levels.pop_front();
               if (rsp_brightness !== want.brightness || rsp_mode !== want.mode ||
                   rsp_cycle_done !== want.cycle_done) begin
                  fault_count++;
                  $display("%0t: response mismatch: expected bright=%0d mode=%0d done=%0d,%s",
                           $time, want.brightness, want.mode, want.cycle_done,
                           $sformatf(" got bright=%0d mode=%0d done=%0d",
                                     rsp_brightness, rsp_mode, rsp_cycle_done));
               end
            end
         end

         // request transfer: predict its response
         if (req_valid && req_ready) begin
            predict_breath(lbt_pkg::cmd_type'(req_command), req_cycle_duration,
                           req_start_delay, want);
            pending_levels.push_back(want);
         end
      end
      outstanding = pending_levels.size();
   end

endmodule

// ===== tb/led_breathing_triangle_generator_tb.sv =====
// Top of the LED breathing triangle generator testbench: clock, reset, stimulus and verdict.
// Depends on lbt_pkg, the generator RTL and breath_level_checker.
module led_breathing_triangle_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_wr_en;
   logic [lbt_pkg::BRIGHT_W-1:0]  csr_wr_data;
   logic                          req_valid;
   logic                          req_ready;
   logic [1:0]                    req_command;
   logic [lbt_pkg::DUR_W-1:0]     req_cycle_duration;
   logic [lbt_pkg::DELAY_W-1:0]   req_start_delay;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [lbt_pkg::BRIGHT_W-1:0]  rsp_brightness;
   logic [1:0]                    rsp_mode;
   logic                          rsp_cycle_done;

   int fault_count;
   int outstanding;
   int hold_requests = 0;
   bit calm = 1'b0;

   always #2 clock = ~clock;

   led_breathing_triangle_generator uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_cycle_duration (req_cycle_duration),
      .req_start_delay    (req_start_delay),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_brightness     (rsp_brightness),
      .rsp_mode           (rsp_mode),
      .rsp_cycle_done     (rsp_cycle_done)
   );

   breath_level_checker chk (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_cycle_duration (req_cycle_duration),
      .req_start_delay    (req_start_delay),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_brightness     (rsp_brightness),
      .rsp_mode           (rsp_mode),
      .rsp_cycle_done     (rsp_cycle_done),
      .fault_count        (fault_count),
      .outstanding        (outstanding)
   );

   // Watchdog
   initial begin
      #2_000_000;
      $display("led_breathing_triangle_generator_tb: errors");
      $finish;
   end

   // Response side: random stall per transfer, one long hold on request
   initial begin
      int gap;
      int holds_served;
      holds_served = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_requests > holds_served) begin
            gap = 300;
            holds_served++;
         end else begin
            gap = calm ? 0 : $urandom_range(0, 6);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // One request transfer; called and returns at a falling edge
   task automatic send_item(input lbt_pkg::cmd_type c,
                            input logic [lbt_pkg::DUR_W-1:0] dur,
                            input logic [lbt_pkg::DELAY_W-1:0] dly);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c;
      req_cycle_duration <= dur;
      req_start_delay <= dly;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering and wait for every predicted response
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   // Mostly start-then-ticks breaths with random content, some noise commands
   task automatic send_breaths(input int count);
      int sent;
      int ticks;
      logic [lbt_pkg::DUR_W-1:0] dur;
      logic [lbt_pkg::DELAY_W-1:0] dly;
      lbt_pkg::cmd_type start_cmd;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 6) == 0) begin
            send_item(lbt_pkg::cmd_type'($urandom_range(0, 3)),
                      lbt_pkg::DUR_W'($urandom), $urandom);
            sent++;
         end else begin
            // short periods dominate so single breaths complete often
            case ($urandom_range(0, 19))
               0: dur = '0;
               1: dur = 16'd1;
               2: dur = '1;
               3: dur = lbt_pkg::DUR_W'($urandom);
               4, 5: dur = lbt_pkg::DUR_W'($urandom_range(2, 400));
               default: dur = lbt_pkg::DUR_W'($urandom_range(2, 24));
            endcase
            case ($urandom_range(0, 3))
               0: dly = $urandom_range(0, 100);
               1: dly = 32'hFFFF_FFFF - $urandom_range(0, 100);
               default: dly = $urandom;
            endcase
            start_cmd = $urandom_range(0, 1) ? lbt_pkg::CMD_START_CONT
                                             : lbt_pkg::CMD_BREATHE_ONCE;
            send_item(start_cmd, dur, dly);
            ticks = (dur <= 40) ? $urandom_range(1, dur + 3) : $urandom_range(1, 30);
            repeat (ticks) send_item(lbt_pkg::CMD_TICK, lbt_pkg::DUR_W'($urandom), $urandom);
            sent += ticks + 1;
            if ($urandom_range(0, 3) == 0) begin
               send_item(lbt_pkg::CMD_STOP, lbt_pkg::DUR_W'($urandom), $urandom);
               sent++;
            end
         end
      end
   endtask

   // Main stimulus
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_command = lbt_pkg::CMD_TICK;
      req_cycle_duration = '0;
      req_start_delay = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: off-state commands, zero half period, extreme fields, breath completion
      send_item(lbt_pkg::CMD_TICK, '0, '0);
      send_item(lbt_pkg::CMD_STOP, '1, '1);
      send_item(lbt_pkg::CMD_START_CONT, '0, '1);
      send_item(lbt_pkg::CMD_TICK, '1, '1);
      send_item(lbt_pkg::CMD_BREATHE_ONCE, 16'd1, '1);
      send_item(lbt_pkg::CMD_TICK, '0, '0);
      send_item(lbt_pkg::CMD_STOP, '0, '0);
      send_item(lbt_pkg::CMD_START_CONT, '1, '1);
      send_item(lbt_pkg::CMD_TICK, '0, '0);
      send_item(lbt_pkg::CMD_TICK, '1, '1);
      send_item(lbt_pkg::CMD_BREATHE_ONCE, 16'd4, '0);
      repeat (4) send_item(lbt_pkg::CMD_TICK, '0, '0);
      send_item(lbt_pkg::CMD_BREATHE_ONCE, 16'd2, 32'd1);
      repeat (3) send_item(lbt_pkg::CMD_TICK, '1, '1);
      send_item(lbt_pkg::CMD_START_CONT, 16'd9, 32'd7);
      send_item(lbt_pkg::CMD_TICK, '0, '0);
      send_item(lbt_pkg::CMD_STOP, '0, '0);
      send_item(lbt_pkg::CMD_TICK, '0, '0);
      send_item(lbt_pkg::CMD_BREATHE_ONCE, '1, '0);
      send_item(lbt_pkg::CMD_TICK, '0, '0);
      drain_results();

      // random phases across peak settings, register written only while idle
      for (int p = 0; p < 8; p++) begin
         csr_wr_en <= 1'b1;
         case (p)
            0: csr_wr_data <= '0;
            1: csr_wr_data <= '1;
            2: csr_wr_data <= 8'd1;
            3: csr_wr_data <= 8'd128;
            default: csr_wr_data <= lbt_pkg::BRIGHT_W'($urandom_range(0, 255));
         endcase
         @(negedge clock);
         csr_wr_en <= 1'b0;
         calm = (p == 2) || (p == 3) || ($urandom_range(0, 3) == 0);
         // long response hold while requests keep coming
         if (p == 3) hold_requests++;
         send_breaths(150);
         drain_results();
      end

      repeat (40) @(negedge clock);
      if (fault_count == 0 && outstanding == 0)
         $display("led_breathing_triangle_generator_tb: clean");
      else
         $display("led_breathing_triangle_generator_tb: errors");
      $finish;
   end

endmodule
